// File: src/utf8sd_pkg.sv
// package: transaction types, constants and the lead byte decode for the utf-8 stream decoder
package utf8sd_pkg;

   localparam int ByteWidth  = 8;
   localparam int CodeWidth  = 32;
   localparam int CountWidth = 4;
   localparam int RemWidth   = 3;
   localparam int ChunkWidth = 6;

   localparam logic [ByteWidth-1:0]  PayloadMask = 8'h3f;
   localparam logic [CountWidth-1:0] LenAscii    = 4'd0;
   localparam logic [CountWidth-1:0] LenStray    = 4'd1;
   localparam logic [CountWidth-1:0] LenSingle   = 4'd1;

   typedef struct packed {
      logic [ByteWidth-1:0] byte_value;
      logic                 end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [CodeWidth-1:0]  code_point;
      logic [CountWidth-1:0] byte_count;
   } rsp_type;

   // run of leading ones, 0 to 8
   function automatic logic [CountWidth-1:0] lead_ones(input logic [ByteWidth-1:0] b);
      logic [CountWidth-1:0] n;
      priority casez (b)
         8'b0???????: n = 4'd0;
         8'b10??????: n = 4'd1;
         8'b110?????: n = 4'd2;
         8'b1110????: n = 4'd3;
         8'b11110???: n = 4'd4;
         8'b111110??: n = 4'd5;
         8'b1111110?: n = 4'd6;
         8'b11111110: n = 4'd7;
         default:     n = 4'd8;
      endcase
      return n;
   endfunction

endpackage

// File: src/utf8_stream_decoder_unit.sv
// top level: lenient utf-8 byte stream decoder with a registered result stage
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_data (byte_value, end_of_buffer)
//   rsp      out        rsp_valid/rsp_stall  rsp_data (code_point, byte_count)
//
// one byte is taken each cycle while req_stall is low; lead decode, mask and shift sit
// between the sequence state registers and the result register, so a result shows in
// the cycle after the byte that completes it. reset clears the sequence state and the
// result valid flag. req_stall is raised only while a result waits in the result
// register and rsp_stall holds it; a taken result frees the slot in the same cycle.
module utf8_stream_decoder_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  utf8sd_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output utf8sd_pkg::rsp_type rsp_data
);

   logic [utf8sd_pkg::RemWidth-1:0]   bytes_remaining_ff, bytes_remaining_in;
   logic [utf8sd_pkg::CountWidth-1:0] sequence_length_ff, sequence_length_in;
   logic [utf8sd_pkg::CodeWidth-1:0]  code_accumulator_ff, code_accumulator_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   utf8sd_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic                              req_take;
   logic                              rsp_take;
   logic                              emit;
   logic [utf8sd_pkg::CountWidth-1:0] lead_n;
   logic [utf8sd_pkg::ByteWidth-1:0]  seed;
   logic [utf8sd_pkg::CodeWidth-1:0]  acc_shift;
   logic [utf8sd_pkg::RemWidth-1:0]   rem_dec;

   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   assign lead_n    = utf8sd_pkg::lead_ones(req_data.byte_value);
   assign seed      = req_data.byte_value & (8'hff >> lead_n);
   assign acc_shift = {code_accumulator_ff[utf8sd_pkg::CodeWidth-utf8sd_pkg::ChunkWidth-1:0],
                       req_data.byte_value[utf8sd_pkg::ChunkWidth-1:0]};
   assign rem_dec   = bytes_remaining_ff - 3'd1;

   always_comb begin
      bytes_remaining_in  = bytes_remaining_ff;
      sequence_length_in  = sequence_length_ff;
      code_accumulator_in = code_accumulator_ff;
      emit                = 1'b0;
      rsp_data_in         = rsp_data_ff;
      if (req_take) begin
         if (bytes_remaining_ff == '0) begin
            if (lead_n == utf8sd_pkg::LenAscii) begin
               emit        = 1'b1;
               rsp_data_in = '{code_point: {24'd0, req_data.byte_value},
                               byte_count: utf8sd_pkg::LenSingle};
            end else if (lead_n == utf8sd_pkg::LenStray) begin
               emit        = 1'b1;
               rsp_data_in = '{code_point: {24'd0,
                                            req_data.byte_value & utf8sd_pkg::PayloadMask},
                               byte_count: utf8sd_pkg::LenSingle};
            end else if (req_data.end_of_buffer) begin
               bytes_remaining_in  = '0;
               sequence_length_in  = '0;
               code_accumulator_in = '0;
            end else begin
               code_accumulator_in = {24'd0, seed};
               sequence_length_in  = lead_n;
               bytes_remaining_in  = 3'(lead_n - 4'd1);
            end
         end else begin
            if (rem_dec == '0) begin
               emit                = 1'b1;
               rsp_data_in         = '{code_point: acc_shift, byte_count: sequence_length_ff};
               bytes_remaining_in  = '0;
               sequence_length_in  = '0;
               code_accumulator_in = '0;
            end else if (req_data.end_of_buffer) begin
               // cut short by end of buffer: drop the pending sequence
               bytes_remaining_in  = '0;
               sequence_length_in  = '0;
               code_accumulator_in = '0;
            end else begin
               code_accumulator_in = acc_shift;
               bytes_remaining_in  = rem_dec;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_remaining_ff  <= '0;
         sequence_length_ff  <= '0;
         code_accumulator_ff <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         bytes_remaining_ff  <= bytes_remaining_in;
         sequence_length_ff  <= sequence_length_in;
         code_accumulator_ff <= code_accumulator_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a pending sequence always has more bytes in total than still expected
   a_len_covers_rem: assert property (@(posedge clock) disable iff (reset)
      bytes_remaining_ff != '0 |-> sequence_length_ff > 4'(bytes_remaining_ff))
      else $error("sequence length below remaining count");

   // every result carries a byte count of 1 to 8
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.byte_count != 4'd0 && rsp_data_ff.byte_count <= 4'd8))
      else $error("byte count out of range");

   // the input is held back only while a result is waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with empty result register");

   // a completing continuation byte always produces a result
   a_complete_emits: assert property (@(posedge clock) disable iff (reset)
      req_take && bytes_remaining_ff == 3'd1 |=> rsp_valid_ff && bytes_remaining_ff == '0)
      else $error("completed sequence gave no result");

   // a multi byte lead without end mark opens a sequence
   a_lead_opens: assert property (@(posedge clock) disable iff (reset)
      req_take && bytes_remaining_ff == '0 && lead_n > 4'd1 && !req_data.end_of_buffer
      |=> bytes_remaining_ff != '0)
      else $error("lead byte did not open a sequence");

endmodule
